### rtl/htfl_pkg.sv
package htfl_pkg;

    // command codes
    localparam logic [2:0] CMD_INIT     = 3'd0;
    localparam logic [2:0] CMD_BIND     = 3'd1;
    localparam logic [2:0] CMD_RELEASE  = 3'd2;
    localparam logic [2:0] CMD_FIND     = 3'd3;
    localparam logic [2:0] CMD_IDENTIFY = 3'd4;

    // status codes
    localparam logic [1:0] STS_OK        = 2'd0;
    localparam logic [1:0] STS_EXHAUSTED = 2'd1;
    localparam logic [1:0] STS_BAD_ID    = 2'd2;
    localparam logic [1:0] STS_NOT_FOUND = 2'd3;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_EXEC,
        S_INIT
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic capture;
        logic exec;
        logic sweep;
        logic sweep_start;
        logic emit_init;
    } t_ctl;

    // datapath to controller
    typedef struct packed {
        logic sweep_last;
    } t_sts;

    // one slot entry: type, owner and free-list link
    typedef struct packed {
        logic [3:0] typ;
        logic [7:0] owner;
        logic [7:0] nxt;
    } t_meta;

endpackage

### rtl/htfl_ctrl.sv
module htfl_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [2:0]        i_cmd,
    input  htfl_pkg::t_sts    i_sts,
    output htfl_pkg::t_ctl    o_ctl,
    output logic              o_busy
);

    htfl_pkg::t_state r_state;
    htfl_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= htfl_pkg::S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_ctl   = '0;
        o_busy  = 1'b1;
        case (r_state)
            htfl_pkg::S_IDLE: begin
                o_busy = 1'b0;
                if (i_start) begin
                    o_ctl.capture = 1'b1;
                    if (i_cmd == htfl_pkg::CMD_INIT) begin
                        o_ctl.sweep_start = 1'b1;
                        n_state = htfl_pkg::S_INIT;
                    end else begin
                        n_state = htfl_pkg::S_EXEC;
                    end
                end
            end
            htfl_pkg::S_EXEC: begin
                o_ctl.exec = 1'b1;
                n_state = htfl_pkg::S_IDLE;
            end
            htfl_pkg::S_INIT: begin
                o_ctl.sweep = 1'b1;
                if (i_sts.sweep_last) begin
                    o_ctl.emit_init = 1'b1;
                    n_state = htfl_pkg::S_IDLE;
                end
            end
            htfl_pkg::S_CLEAR: begin
                o_ctl.sweep = 1'b1;
                if (i_sts.sweep_last) begin
                    n_state = htfl_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = htfl_pkg::S_IDLE;
            end
        endcase
    end

    a_exec_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ctl.exec |=> !o_ctl.exec)
        else $error("exec lasted more than one cycle");

endmodule

### rtl/htfl_datapath.sv
module htfl_datapath #(
    parameter int DEPTH = 256,
    parameter int REF_W = 32
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  htfl_pkg::t_ctl    i_ctl,
    output htfl_pkg::t_sts    o_sts,
    input  logic [2:0]        i_cmd,
    input  logic [7:0]        i_handle_id,
    input  logic [3:0]        i_res_type,
    input  logic [7:0]        i_owner_id,
    input  logic [31:0]       i_object_ref,
    input  logic              i_cfg_we,
    input  logic [8:0]        i_cfg_wdata,
    output logic              o_strobe,
    output logic [1:0]        o_status,
    output logic [7:0]        o_result_id,
    output logic [31:0]       o_result_ref,
    output logic [7:0]        o_result_owner
);

    localparam int AW = $clog2(DEPTH);
    localparam int LIM = (DEPTH < 256) ? DEPTH : 256;
    localparam logic [8:0] LIM9 = 9'(LIM);

    function automatic logic [AW-1:0] to_addr(input logic [7:0] a);
        logic [AW+7:0] w;
        w = {{AW{1'b0}}, a};
        return w[AW-1:0];
    endfunction

    // captured request
    logic [2:0]       r_cmd;
    logic [7:0]       r_id;
    logic [3:0]       r_type;
    logic [7:0]       r_owner;
    logic [REF_W-1:0] r_obj;

    logic [7:0]       r_head;
    logic [8:0]       r_tsize;
    logic [7:0]       r_cnt;
    logic [8:0]       r_sweep_n;

    htfl_pkg::t_meta  mem_meta [DEPTH];
    logic [REF_W-1:0] mem_ref  [DEPTH];
    htfl_pkg::t_meta  r_rd_meta;
    logic [REF_W-1:0] r_rd_ref;

    logic              r_strobe;
    logic [1:0]        r_status;
    logic [7:0]        r_result_id;
    logic [31:0]       r_result_ref;
    logic [7:0]        r_result_owner;

    logic [8:0]        eff_n;
    logic              id_ok;
    logic              head_ok;
    logic [1:0]        res_status;
    logic [7:0]        res_id;
    logic [REF_W-1:0]  res_ref;
    logic [7:0]        res_owner;
    logic              meta_we;
    logic [7:0]        waddr;
    htfl_pkg::t_meta   wmeta;
    logic              ref_we;
    logic              head_we;
    logic [7:0]        head_val;
    logic [8:0]        cnt_inc;
    logic [7:0]        sweep_next;
    logic [7:0]        raddr;
    logic [REF_W+31:0] obj_wide;
    logic [REF_W+31:0] ref_wide;

    assign eff_n = (r_tsize < 9'd2) ? 9'd2 : ((r_tsize > LIM9) ? LIM9 : r_tsize);
    assign id_ok = {1'b0, r_id} < eff_n;
    assign head_ok = (r_head != 8'd0) && ({1'b0, r_head} < eff_n);

    assign cnt_inc = {1'b0, r_cnt} + 9'd1;
    assign sweep_next = (cnt_inc < r_sweep_n) ? cnt_inc[7:0] : 8'd0;
    assign o_sts.sweep_last = ({1'b0, r_cnt} == (LIM9 - 9'd1));

    assign raddr = (i_cmd == htfl_pkg::CMD_BIND) ? r_head : i_handle_id;
    assign obj_wide = {{REF_W{1'b0}}, i_object_ref};
    assign ref_wide = {32'd0, res_ref};

    always_comb begin
        res_status = htfl_pkg::STS_OK;
        res_id     = r_id;
        res_ref    = '0;
        res_owner  = 8'd0;
        meta_we    = 1'b0;
        waddr      = r_id;
        wmeta      = r_rd_meta;
        ref_we     = 1'b0;
        head_we    = 1'b0;
        head_val   = r_rd_meta.nxt;
        case (r_cmd)
            htfl_pkg::CMD_BIND: begin
                res_id = 8'd0;
                if (r_type == 4'd0) begin
                    res_status = htfl_pkg::STS_BAD_ID;
                end else if (!head_ok || r_rd_meta.typ != 4'd0) begin
                    res_status = htfl_pkg::STS_EXHAUSTED;
                end else begin
                    res_id      = r_head;
                    meta_we     = 1'b1;
                    ref_we      = 1'b1;
                    waddr       = r_head;
                    wmeta.typ   = r_type;
                    wmeta.owner = r_owner;
                    head_we     = 1'b1;
                    head_val    = r_rd_meta.nxt;
                end
            end
            htfl_pkg::CMD_RELEASE: begin
                if (r_id == 8'd0 || !id_ok || r_rd_meta.typ == 4'd0) begin
                    res_status = htfl_pkg::STS_BAD_ID;
                end else begin
                    meta_we     = 1'b1;
                    wmeta.typ   = 4'd0;
                    wmeta.owner = 8'd0;
                    wmeta.nxt   = r_head;
                    head_we     = 1'b1;
                    head_val    = r_id;
                end
            end
            htfl_pkg::CMD_FIND: begin
                if (!id_ok) begin
                    res_status = htfl_pkg::STS_BAD_ID;
                end else if (r_rd_meta.typ == 4'd0 || r_rd_meta.typ != r_type) begin
                    res_status = htfl_pkg::STS_NOT_FOUND;
                end else begin
                    res_ref = r_rd_ref;
                end
            end
            htfl_pkg::CMD_IDENTIFY: begin
                if (!id_ok || r_rd_meta.typ == 4'd0) begin
                    res_status = htfl_pkg::STS_BAD_ID;
                end else begin
                    res_owner = r_rd_meta.owner;
                end
            end
            default: begin
                res_status = htfl_pkg::STS_BAD_ID;
            end
        endcase
    end

    // slot memories
    always_ff @(posedge i_clk) begin
        if (i_ctl.sweep) begin
            mem_meta[to_addr(r_cnt)] <= '{typ: 4'd0, owner: 8'd0, nxt: sweep_next};
        end else if (i_ctl.exec && meta_we) begin
            mem_meta[to_addr(waddr)] <= wmeta;
        end
        if (i_ctl.capture) begin
            r_rd_meta <= mem_meta[to_addr(raddr)];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.exec && ref_we) begin
            mem_ref[to_addr(r_head)] <= r_obj;
        end
        if (i_ctl.capture) begin
            r_rd_ref <= mem_ref[to_addr(raddr)];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.capture) begin
            r_cmd   <= i_cmd;
            r_id    <= i_handle_id;
            r_type  <= i_res_type;
            r_owner <= i_owner_id;
            r_obj   <= obj_wide[REF_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head    <= 8'd1;
            r_tsize   <= 9'd256;
            r_cnt     <= 8'd0;
            r_sweep_n <= LIM9;
            r_strobe  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_tsize <= i_cfg_wdata;
            end
            if (i_ctl.sweep_start) begin
                r_cnt     <= 8'd0;
                r_sweep_n <= eff_n;
            end else if (i_ctl.sweep) begin
                r_cnt <= cnt_inc[7:0];
            end
            if (i_ctl.sweep && o_sts.sweep_last) begin
                r_head <= 8'd1;
            end else if (i_ctl.exec && head_we) begin
                r_head <= head_val;
            end
            r_strobe <= i_ctl.exec || i_ctl.emit_init;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.exec) begin
            r_status       <= res_status;
            r_result_id    <= res_id;
            r_result_ref   <= ref_wide[31:0];
            r_result_owner <= res_owner;
        end else if (i_ctl.emit_init) begin
            r_status       <= htfl_pkg::STS_OK;
            r_result_id    <= r_id;
            r_result_ref   <= 32'd0;
            r_result_owner <= 8'd0;
        end
    end

    assign o_strobe       = r_strobe;
    assign o_status       = r_status;
    assign o_result_id    = r_result_id;
    assign o_result_ref   = r_result_ref;
    assign o_result_owner = r_result_owner;

    a_no_slot0_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_ctl.exec && meta_we) |-> (waddr != 8'd0))
        else $error("reserved slot zero written by a request");

    a_strobe_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(i_ctl.exec || i_ctl.emit_init))
        else $error("result strobe without a finished request");

endmodule

### rtl/handle_table_free_list.sv
// bind, release, find, identify: slot read registered at accept, result registered from exec
// init sweeps min(DEPTH,256) slots, one per cycle, result registered from the last sweep step
// one request at a time: busy stays high through the registered slot memory read and write-back
// reset: synchronous active-low; a clearing pass over min(DEPTH,256) slots follows with busy high
// results are a one-cycle strobe; the receiver cannot stall
module handle_table_free_list #(
    parameter int DEPTH = 256,
    parameter int REF_W = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // request side
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  i_cmd,
    input  logic [7:0]  i_handle_id,
    input  logic [3:0]  i_res_type,
    input  logic [7:0]  i_owner_id,
    input  logic [31:0] i_object_ref,
    // table size register
    input  logic        i_cfg_we,
    input  logic [8:0]  i_cfg_wdata,
    // result side
    output logic        o_strobe,
    output logic [1:0]  o_status,
    output logic [7:0]  o_result_id,
    output logic [31:0] o_result_ref,
    output logic [7:0]  o_result_owner
);

    // controller sequences each request: idle -> exec for lookups and list updates,
    // idle -> init sweep for init, and a clear sweep right after reset
    htfl_pkg::t_ctl ctl;
    htfl_pkg::t_sts sts;

    htfl_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_cmd   (i_cmd),
        .i_sts   (sts),
        .o_ctl   (ctl),
        .o_busy  (busy)
    );

    // datapath holds the slot memories, free-list head, size register and result regs
    htfl_datapath #(
        .DEPTH (DEPTH),
        .REF_W (REF_W)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_ctl          (ctl),
        .o_sts          (sts),
        .i_cmd          (i_cmd),
        .i_handle_id    (i_handle_id),
        .i_res_type     (i_res_type),
        .i_owner_id     (i_owner_id),
        .i_object_ref   (i_object_ref),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .o_strobe       (o_strobe),
        .o_status       (o_status),
        .o_result_id    (o_result_id),
        .o_result_ref   (o_result_ref),
        .o_result_owner (o_result_owner)
    );

    // an accepted request always keeps the block busy for the next cycle
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("block not busy after accepting a request");

endmodule
